/* src/obm_pkg.sv */
// Shared types, request codes and field widths for the multicart outer bank mapper.
package obm_pkg;

  localparam int KindW   = 2;
  localparam int DataW   = 8;
  localparam int WindowW = 3;
  localparam int BankW   = 12;
  localparam int DipW    = 3;
  localparam int IdxW    = 2;

  localparam int InTdataW  = 16;
  localparam int OutTdataW = 24;

  localparam logic [KindW-1:0] KIND_WRITE = 2'd0;
  localparam logic [KindW-1:0] KIND_CHR   = 2'd1;
  localparam logic [KindW-1:0] KIND_PRG   = 2'd2;
  localparam logic [KindW-1:0] KIND_READ  = 2'd3;

  localparam logic [DataW-1:0] REG0_RESET = 8'h00;
  localparam logic [DataW-1:0] REG1_RESET = 8'h00;
  localparam logic [DataW-1:0] REG2_RESET = 8'h0F;
  localparam logic [DataW-1:0] REG3_RESET = 8'h00;
  localparam logic [DipW-1:0]  DIP_RESET  = 3'd7;

  // Outer bank state seen by the translate logic
  typedef struct packed {
    logic [DataW-1:0] reg0;
    logic [DataW-1:0] reg1;
    logic [DataW-1:0] reg2;
    logic [DataW-1:0] reg3;
    logic [DipW-1:0]  dip;
  } outer_state_t;

  // One request held in the input register
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [DataW-1:0]   data;
    logic [WindowW-1:0] window;
  } request_t;

  typedef struct packed {
    logic [BankW-1:0]   bank;
    logic [WindowW-1:0] window_out;
    logic               open_bus;
    logic               write_taken;
  } result_t;

endpackage

/* src/multicart_outer_bank_mapper.sv */
// Multicart outer bank mapper: input register, translate logic, result register.
// Throughput: one request per cycle; the input register and the result register each take a
// new request whenever the stage after them is empty or drains in the same cycle.
// Reset clears both valid flags, the write index, the outer registers (00, 00, 0F, 00)
// and sets the DIP switch register to 7.
module multicart_outer_bank_mapper (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [obm_pkg::DipW-1:0]        cfg_wr_data,     // dip_switch
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [obm_pkg::InTdataW-1:0]    s_axis_tdata,    // data[7:0], window[10:8], zeros
  input  logic [obm_pkg::KindW-1:0]       s_axis_tuser,    // kind[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // bank[11:0], window_out[14:12], open_bus[15], write_taken[16], zeros
  output logic [obm_pkg::OutTdataW-1:0]   m_axis_tdata
);

  obm_pkg::request_t     req;
  logic                  req_valid;
  logic                  req_advance;
  obm_pkg::outer_state_t state;
  obm_pkg::result_t      res_next;
  obm_pkg::result_t      res;
  logic                  res_valid;

  // advance the held request when the result register is free or drains now
  assign req_advance   = req_valid && (!res_valid || m_axis_tready);
  assign s_axis_tready = !req_valid || req_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req.kind   <= s_axis_tuser;
      req.data   <= s_axis_tdata[7:0];
      req.window <= s_axis_tdata[10:8];
    end
  end

  obm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_en       (req_advance && (req.kind == obm_pkg::KIND_WRITE)),
    .wr_data     (req.data),
    .state       (state)
  );

  obm_xlate u_xlate (
    .req   (req),
    .state (state),
    .res   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_advance) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {7'd0, res.write_taken, res.open_bus, res.window_out, res.bank};

endmodule

/* src/obm_regs.sv */
// Outer bank registers, rotating write index and DIP switch register.
module obm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [obm_pkg::DipW-1:0]    cfg_wr_data,
  input  logic                        wr_en,
  input  logic [obm_pkg::DataW-1:0]   wr_data,
  output obm_pkg::outer_state_t       state
);

  logic [obm_pkg::DataW-1:0] outer_regs [4];
  logic [obm_pkg::IdxW-1:0]  write_index;
  logic [obm_pkg::DipW-1:0]  dip;
  logic                      locked;

  assign locked = outer_regs[3][6];

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_regs[0] <= obm_pkg::REG0_RESET;
      outer_regs[1] <= obm_pkg::REG1_RESET;
      outer_regs[2] <= obm_pkg::REG2_RESET;
      outer_regs[3] <= obm_pkg::REG3_RESET;
      write_index   <= '0;
      dip           <= obm_pkg::DIP_RESET;
    end else begin
      if (cfg_wr_en) begin
        dip <= cfg_wr_data;
      end
      // drop writes once register 3 has locked the bank
      if (wr_en && !locked) begin
        outer_regs[write_index] <= wr_data;
        write_index             <= write_index + 2'd1;
      end
    end
  end

  assign state.reg0 = outer_regs[0];
  assign state.reg1 = outer_regs[1];
  assign state.reg2 = outer_regs[2];
  assign state.reg3 = outer_regs[3];
  assign state.dip  = dip;

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    locked |=> locked)
    else $error("outer register lock released");

  a_index_hold: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && !locked) |=> $stable(write_index))
    else $error("write index moved without a taken write");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !locked) |=> write_index == $past(write_index) + 2'd1)
    else $error("write index did not advance on a taken write");

endmodule

/* src/obm_xlate.sv */
// Bank translation, open-bus check and write status for one request.
module obm_xlate (
  input  obm_pkg::request_t      req,
  input  obm_pkg::outer_state_t  state,
  output obm_pkg::result_t       res
);

  logic [3:0]                  chr_shift;
  logic [obm_pkg::DataW-1:0]   chr_keep;
  logic [obm_pkg::BankW-1:0]   chr_bank;
  logic [4:0]                  prg_keep;
  logic [obm_pkg::DataW-1:0]   prg_outer;
  logic [obm_pkg::BankW-1:0]   prg_bank;

  always_comb begin
    chr_shift = ~state.reg2[3:0];
    chr_keep  = 8'hFF >> chr_shift;
    chr_bank  = {state.reg2[7:4], state.reg0 | (req.data & chr_keep)};

    prg_keep  = ~state.reg3[4:0];
    prg_outer = {state.reg2[7],
                 state.dip[2] ? state.reg2[6] : state.reg1[5],
                 state.dip[1] ? state.reg2[5] : state.reg1[6],
                 state.reg1[4:0]};
    prg_bank  = {4'd0, prg_outer | {3'd0, req.data[4:0] & prg_keep}};

    res.bank        = '0;
    res.window_out  = req.window;
    res.open_bus    = 1'b0;
    res.write_taken = 1'b0;
    case (req.kind)
      obm_pkg::KIND_WRITE: res.write_taken = ~state.reg3[6];
      obm_pkg::KIND_CHR:   res.bank = chr_bank;
      obm_pkg::KIND_PRG:   res.bank = prg_bank;
      obm_pkg::KIND_READ:  res.open_bus = state.dip[0] & state.reg1[7];
      default:             res.bank = '0;
    endcase
  end

endmodule

/* dv/tb_multicart_outer_bank_mapper.sv */
// Self-checking testbench for the multicart outer bank mapper stream block.
module tb_multicart_outer_bank_mapper;
  import obm_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int HoldOff   = 200;
  localparam int PhaseLen  = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [DipW-1:0]      cfg_wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [KindW-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  // Mapper state as the testbench sees it
  logic [DataW-1:0] outer_reg [4];
  logic [IdxW-1:0]  wr_slot;
  logic [DipW-1:0]  dip_sel;

  result_t pending_results [$];
  int      err_count = 0;
  int      idle_cycles = 0;
  int      ready_hold_req = 0;
  int      stall_left = 0;
  bit      no_idle = 1'b0;
  bit      allow_lock = 1'b0;

  multicart_outer_bank_mapper uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out the result of one request and advance the mapper state
  function automatic result_t map_request(request_t rq);
    result_t          res;
    logic [DataW-1:0] chr_keep;
    logic [4:0]       prg_keep;
    logic [DataW-1:0] prg_outer;
    res = '0;
    res.window_out = rq.window;
    case (rq.kind)
      KIND_WRITE: begin
        if (!outer_reg[3][6]) begin
          outer_reg[wr_slot] = rq.data;
          wr_slot = wr_slot + 2'd1;
          res.write_taken = 1'b1;
        end
      end
      KIND_CHR: begin
        chr_keep = 8'hFF >> (~outer_reg[2][3:0]);
        res.bank = {4'h0, outer_reg[0]} | {outer_reg[2][7:4], 8'h00}
                   | {4'h0, rq.data & chr_keep};
      end
      KIND_PRG: begin
        prg_keep = ~outer_reg[3][4:0];
        prg_outer = {outer_reg[2][7], 2'b00, outer_reg[1][4:0]};
        prg_outer[5] = dip_sel[1] ? outer_reg[2][5] : outer_reg[1][6];
        prg_outer[6] = dip_sel[2] ? outer_reg[2][6] : outer_reg[1][5];
        res.bank = {4'h0, prg_outer | {3'b000, rq.data[4:0] & prg_keep}};
      end
      default: begin
        res.open_bus = dip_sel[0] & outer_reg[1][7];
      end
    endcase
    return res;
  endfunction

  // Check the oldest expectation against each result, then predict each accepted request
  always @(posedge clk) begin
    result_t  want;
    result_t  got;
    request_t rq;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.bank        = m_axis_tdata[11:0];
      got.window_out  = m_axis_tdata[14:12];
      got.open_bus    = m_axis_tdata[15];
      got.write_taken = m_axis_tdata[16];
      if (pending_results.size() == 0) begin
        $error("result %0h arrived with no request pending", m_axis_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.bank != want.bank) begin
          $error("bank: expected %0h, got %0h", want.bank, got.bank);
          err_count++;
        end
        if (got.window_out != want.window_out) begin
          $error("window_out: expected %0d, got %0d", want.window_out, got.window_out);
          err_count++;
        end
        if (got.open_bus != want.open_bus) begin
          $error("open_bus: expected %0b, got %0b", want.open_bus, got.open_bus);
          err_count++;
        end
        if (got.write_taken != want.write_taken) begin
          $error("write_taken: expected %0b, got %0b", want.write_taken, got.write_taken);
          err_count++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      rq.kind   = s_axis_tuser;
      rq.data   = s_axis_tdata[7:0];
      rq.window = s_axis_tdata[10:8];
      pending_results.push_back(map_request(rq));
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (ready_hold_req > 0) begin
      stall_left = ready_hold_req;
      ready_hold_req = 0;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left = rand_gap();
    end
  end

  task automatic send_request(input logic [KindW-1:0] kind, input logic [DataW-1:0] data,
                              input logic [WindowW-1:0] window);
    int gap;
    gap = rand_gap();
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b00000, window, data};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    // let the predictor take the accepted request before the next one is chosen
    #1;
  endtask

  task automatic send_random();
    logic [KindW-1:0] kind;
    logic [DataW-1:0] data;
    kind = 2'($urandom_range(0, 3));
    data = 8'($urandom_range(0, 255));
    // Keep register 3 unlocked until the lock test
    if (kind == KIND_WRITE && wr_slot == 2'd3 && !allow_lock) data[6] = 1'b0;
    send_request(kind, data, 3'($urandom_range(0, 7)));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_dip(input logic [DipW-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    dip_sel = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_request(KIND_CHR, 8'hFF, 3'd0);
    send_request(KIND_PRG, 8'hFF, 3'd7);
    send_request(KIND_READ, 8'h00, 3'd5);
    send_request(KIND_CHR, 8'h00, 3'd2);
  endtask

  task automatic test_outer_extremes();
    send_request(KIND_WRITE, 8'hFF, 3'd0);
    send_request(KIND_WRITE, 8'h80, 3'd1);
    send_request(KIND_WRITE, 8'hF0, 3'd2);
    send_request(KIND_WRITE, 8'h1F, 3'd3);
    send_request(KIND_CHR, 8'hFF, 3'd7);
    send_request(KIND_PRG, 8'h00, 3'd4);
    send_request(KIND_READ, 8'hFF, 3'd6);
  endtask

  // Register 1 bits 5/6 set and register 2 bits 5/6 clear show each DIP source
  task automatic test_dip_sources();
    logic [DipW-1:0] dips [4] = '{3'd0, 3'd2, 3'd4, 3'd6};
    send_request(KIND_WRITE, 8'h00, 3'd0);
    send_request(KIND_WRITE, 8'h7F, 3'd1);
    send_request(KIND_WRITE, 8'h9F, 3'd2);
    send_request(KIND_WRITE, 8'h00, 3'd3);
    foreach (dips[i]) begin
      set_dip(dips[i]);
      send_request(KIND_PRG, 8'hFF, 3'd1);
      send_request(KIND_READ, 8'h00, 3'd3);
    end
  endtask

  task automatic test_random_phases();
    logic [DipW-1:0] phase_dip;
    for (int p = 0; p < 7; p++) begin
      phase_dip = (p == 0) ? 3'd0 : (p == 1) ? 3'd7 : 3'($urandom_range(0, 7));
      set_dip(phase_dip);
      no_idle = (p == 3);
      repeat (PhaseLen) send_random();
      no_idle = 1'b0;
    end
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    wait_drained();
    ready_hold_req = HoldOff;
    no_idle = 1'b1;
    repeat (40) send_random();
    no_idle = 1'b0;
  endtask

  task automatic test_write_lock();
    set_dip(3'd7);
    while (wr_slot != 2'd3) send_random();
    send_request(KIND_WRITE, 8'h40 | 8'($urandom_range(0, 255)), 3'd2);
    allow_lock = 1'b1;
    send_request(KIND_WRITE, 8'h55, 3'd0);
    repeat (150) send_random();
  endtask

  initial begin
    outer_reg[0] = REG0_RESET;
    outer_reg[1] = REG1_RESET;
    outer_reg[2] = REG2_RESET;
    outer_reg[3] = REG3_RESET;
    wr_slot = '0;
    dip_sel = DIP_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_outer_extremes();
    test_dip_sources();
    test_random_phases();
    test_backpressure();
    test_write_lock();

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
